[rtl/ddu_pkg.sv]
package ddu_pkg;

    // Widths of the data path and of the configuration index.
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_VALUE = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [WORD_W-1:0] PRIME_BASE_RST  = 64'd2;
    localparam logic [WORD_W-1:0] LIMIT_VALUE_RST = 64'd1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // Sequencer states: table build after a configuration write, then rank lookup.
    typedef enum logic [3:0] {
        S_IDLE,
        S_B_INIT,
        S_B_DIV,
        S_B_DIVW,
        S_B_TOTW,
        S_B_PWRW,
        S_R_RD,
        S_R_DIV,
        S_R_DIVW,
        S_R_MULW,
        S_OUT
    } t_state;

endpackage

[rtl/digit_dominated_unrank_top.sv]
// Digit-dominated unranking: returns the k-th number whose base-p digits are
// each at most the matching base-p digit of the limit q.
// Configuration: write prime_base (index 0) or limit_value (index 1) on the
// cfg channel. Each write rebuilds the digit table: one serial divide plus two
// multiplies per base-p digit of q.
// Writes to other indexes are taken and ignored. busy is high while building.
// Rank: pulse start with i_rank while busy is low. The block answers with one
// result beat marked by o_done, held for exactly one cycle; the receiver
// cannot hold it off. Invalid cases and out-of-range ranks give their beat in
// the cycle after acceptance, and the next rank is taken once busy falls.
// A valid rank walks the digits of q (up to MAX_DIGITS of them) with one serial
// divide and one multiply per digit, the multiplier built from 32x32 partial
// products, and gives its beat when the walk ends; the next rank waits for
// the return to idle.
// One rank is in flight at a time; busy stays high until its beat is out.
// Reset leaves prime_base 2, limit_value 1 and the case invalid until the
// first configuration write; every rank then answers status 1.
// The table memory is never cleared; only entries below the digit count of
// a completed build are read.
module digit_dominated_unrank_top #(
    parameter int unsigned MAX_DIGITS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ddu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ddu_pkg::WORD_W-1:0]     i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [ddu_pkg::WORD_W-1:0]     i_rank,
    output logic                           o_done,
    output logic [ddu_pkg::WORD_W-1:0]     o_index_value,
    output logic [ddu_pkg::WORD_W-1:0]     o_total_count,
    output logic [1:0]                     o_status
);
    import ddu_pkg::*;

    localparam int unsigned AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int unsigned CW    = $clog2(MAX_DIGITS + 1);
    localparam int unsigned ROW_W = 2 * WORD_W;

    t_state            r_state;
    t_state            n_state;
    logic [WORD_W-1:0] r_prime;
    logic [WORD_W-1:0] r_limit;
    logic              r_case_ok;
    logic [CW-1:0]     r_ndig;
    logic [WORD_W-1:0] r_total;
    logic [WORD_W-1:0] r_rest;
    logic [CW-1:0]     r_n;
    logic [WORD_W-1:0] r_wtot;
    logic [WORD_W-1:0] r_pw;
    logic [WORD_W-1:0] r_kr;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_index;
    t_status           r_status;

    logic              cfg_fire;
    logic              cfg_known;
    logic              rank_fire;
    logic              div_start;
    logic [WORD_W-1:0] div_a;
    logic [WORD_W-1:0] div_b;
    logic              div_done;
    logic [WORD_W-1:0] div_quot;
    logic [WORD_W-1:0] div_rem;
    logic              mul_start;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic              mul_done;
    logic [WORD_W-1:0] mul_prod;
    logic              mul_ovf;
    logic              mem_we;
    logic              mem_re;
    logic [ROW_W-1:0]  mem_rdata;
    logic [WORD_W-1:0] radix_new;
    logic [WORD_W:0]   acc_sum;

    assign cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign cfg_known = (i_cfg_index == REG_PRIME_BASE) || (i_cfg_index == REG_LIMIT_VALUE);
    assign rank_fire = start && !busy;
    assign radix_new = div_rem + 1'b1;
    assign acc_sum   = {1'b0, r_acc} + {1'b0, mul_prod};

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cfg_fire && cfg_known) begin
                    n_state = S_B_INIT;
                end else if (rank_fire) begin
                    if (!r_case_ok || (i_rank >= r_total)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_R_RD;
                    end
                end
            end
            S_B_INIT: begin
                if ((r_prime < 64'd2) || (r_limit == '0)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_B_DIV;
                end
            end
            S_B_DIV: begin
                if ((r_rest == '0) || (r_n == CW'(MAX_DIGITS))) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_B_DIVW;
                end
            end
            S_B_DIVW: if (div_done) n_state = S_B_TOTW;
            S_B_TOTW: begin
                if (mul_done) begin
                    n_state = mul_ovf ? S_IDLE : S_B_PWRW;
                end
            end
            S_B_PWRW: if (mul_done) n_state = S_B_DIV;
            S_R_RD: begin
                n_state = (r_n == r_ndig) ? S_OUT : S_R_DIV;
            end
            S_R_DIV:  n_state = S_R_DIVW;
            S_R_DIVW: if (div_done) n_state = S_R_MULW;
            S_R_MULW: begin
                if (mul_done) begin
                    n_state = (mul_ovf || acc_sum[WORD_W]) ? S_OUT : S_R_RD;
                end
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Unit strobes and operands.
    always_comb begin
        div_start = 1'b0;
        div_a     = r_rest;
        div_b     = r_prime;
        mul_start = 1'b0;
        mul_a     = r_wtot;
        mul_b     = radix_new;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        case (r_state)
            S_B_DIV: begin
                div_start = (r_rest != '0) && (r_n != CW'(MAX_DIGITS));
            end
            S_B_DIVW: begin
                mul_start = div_done;
                mem_we    = div_done;
            end
            S_B_TOTW: begin
                mul_start = mul_done && !mul_ovf;
                mul_a     = r_pw;
                mul_b     = r_prime;
            end
            S_R_RD: begin
                mem_re = (r_n != r_ndig);
            end
            S_R_DIV: begin
                div_start = 1'b1;
                div_a     = r_kr;
                div_b     = mem_rdata[ROW_W-1:WORD_W];
            end
            S_R_DIVW: begin
                mul_start = div_done;
                mul_a     = div_rem;
                mul_b     = r_pw;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Configuration registers and the committed case.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime   <= PRIME_BASE_RST;
            r_limit   <= LIMIT_VALUE_RST;
            r_case_ok <= 1'b0;
            r_ndig    <= '0;
            r_total   <= '0;
        end else begin
            if (cfg_fire && (i_cfg_index == REG_PRIME_BASE)) begin
                r_prime <= i_cfg_data;
            end
            if (cfg_fire && (i_cfg_index == REG_LIMIT_VALUE)) begin
                r_limit <= i_cfg_data;
            end
            if (r_state == S_B_INIT) begin
                r_case_ok <= 1'b0;
                r_ndig    <= '0;
                r_total   <= '0;
            end else if ((r_state == S_B_DIV) && (r_rest == '0)) begin
                r_case_ok <= 1'b1;
                r_ndig    <= r_n;
                r_total   <= r_wtot;
            end
        end
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the build and of the rank walk.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n     <= '0;
                r_acc   <= '0;
                r_kr    <= i_rank;
                r_index <= '0;
                if (!r_case_ok) begin
                    r_status <= ST_INVALID;
                end else if (i_rank >= r_total) begin
                    r_status <= ST_RANGE;
                end else begin
                    r_status <= ST_OK;
                end
            end
            S_B_INIT: begin
                r_rest <= r_limit;
                r_n    <= '0;
                r_wtot <= 64'd1;
                r_pw   <= 64'd1;
            end
            S_B_DIVW: begin
                if (div_done) begin
                    r_rest <= div_quot;
                end
            end
            S_B_TOTW: begin
                if (mul_done) begin
                    r_wtot <= mul_prod;
                end
            end
            S_B_PWRW: begin
                if (mul_done) begin
                    r_pw <= mul_prod;
                    r_n  <= r_n + 1'b1;
                end
            end
            S_R_RD: begin
                if (r_n == r_ndig) begin
                    r_index <= r_acc;
                end
            end
            S_R_DIV: begin
                r_pw <= mem_rdata[WORD_W-1:0];
            end
            S_R_DIVW: begin
                if (div_done) begin
                    r_kr <= div_quot;
                end
            end
            S_R_MULW: begin
                if (mul_done) begin
                    if (mul_ovf || acc_sum[WORD_W]) begin
                        r_status <= ST_OVERFLOW;
                        r_index  <= '0;
                    end else begin
                        r_acc <= acc_sum[WORD_W-1:0];
                        r_n   <= r_n + 1'b1;
                    end
                end
            end
            default: begin
                r_n <= r_n;
            end
        endcase
    end

    // Serial divider shared by the digit split and the rank walk.
    ddu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Checked 64x64 multiplier.
    ddu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod),
        .o_ovf   (mul_ovf)
    );

    // Digit table: radix in the upper half, power of p in the lower half.
    ddu_table #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW),
        .DW    (ROW_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata ({radix_new, r_pw}),
        .i_re    (mem_re),
        .i_raddr (r_n[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Ports.
    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE) && !start;
    assign o_done        = (r_state == S_OUT);
    assign o_index_value = r_index;
    assign o_total_count = r_total;
    assign o_status      = r_status;

    // Checks.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beat lasted more than one cycle");

    a_rank_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rank_fire |=> busy)
        else $error("accepted rank did not raise busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_index_value == '0))
        else $error("failed result carries a nonzero value");

    a_cfg_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_fire && cfg_known) |=> busy ##1 !r_case_ok)
        else $error("configuration write did not start a rebuild");

endmodule

[rtl/ddu_div.sv]
module ddu_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ddu_pkg::WORD_W-1:0]  i_dividend,
    input  logic [ddu_pkg::WORD_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [ddu_pkg::WORD_W-1:0]  o_quot,
    output logic [ddu_pkg::WORD_W-1:0]  o_rem
);
    import ddu_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_W);

    logic              r_run;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_div;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;
    logic              fits;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    always_comb begin
        rem_sh = {r_rem, r_quo[WORD_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        fits   = (rem_sh >= {1'b0, r_div});
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(WORD_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[WORD_W-2:0], fits};
            r_rem <= fits ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

[rtl/ddu_mul.sv]
module ddu_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ddu_pkg::WORD_W-1:0]  i_a,
    input  logic [ddu_pkg::WORD_W-1:0]  i_b,
    output logic                        o_done,
    output logic [ddu_pkg::WORD_W-1:0]  o_prod,
    output logic                        o_ovf
);
    import ddu_pkg::*;

    localparam int unsigned PROD_W = 2 * WORD_W;

    logic              r_run;
    logic              r_done;
    logic [2:0]        r_step;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_acc;
    logic [HALF_W-1:0] op_a;
    logic [HALF_W-1:0] op_b;
    logic [PROD_W-1:0] part;

    // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi, one per cycle.
    always_comb begin
        case (r_step)
            3'd0: begin
                op_a = r_a[HALF_W-1:0];
                op_b = r_b[HALF_W-1:0];
            end
            3'd1: begin
                op_a = r_a[HALF_W-1:0];
                op_b = r_b[WORD_W-1:HALF_W];
            end
            3'd2: begin
                op_a = r_a[WORD_W-1:HALF_W];
                op_b = r_b[HALF_W-1:0];
            end
            default: begin
                op_a = r_a[WORD_W-1:HALF_W];
                op_b = r_b[WORD_W-1:HALF_W];
            end
        endcase
    end

    // Align the product registered in the previous step.
    always_comb begin
        case (r_step)
            3'd1:    part = {{WORD_W{1'b0}}, r_prod};
            3'd2:    part = {{HALF_W{1'b0}}, r_prod, {HALF_W{1'b0}}};
            3'd3:    part = {{HALF_W{1'b0}}, r_prod, {HALF_W{1'b0}}};
            3'd4:    part = {r_prod, {WORD_W{1'b0}}};
            default: part = '0;
        endcase
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 1'b1;
                if (r_step == 3'd4) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Product and accumulator.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_run) begin
            r_prod <= WORD_W'(op_a) * WORD_W'(op_b);
            r_acc  <= r_acc + part;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc[WORD_W-1:0];
    assign o_ovf  = |r_acc[PROD_W-1:WORD_W];

endmodule

[rtl/ddu_table.sv]
module ddu_table #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned DW    = 128
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
